// ===== rtl/sobel_edge_magnitude_stream_defines.svh =====
// Assertion macros shared by the checker of the Sobel edge magnitude stream.
// No dependencies; included by the checker file only.
`ifndef SOBEL_EDGE_MAGNITUDE_STREAM_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_STREAM_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define SOBEL_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define SOBEL_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sobel_pkg.sv =====
// Shared types and constants of the Sobel edge magnitude stream.
// No dependencies; used by every module of the block.
`default_nettype none

package sobel_pkg;

   localparam int PIXEL_W          = 8;
   localparam int CSR_DATA_W       = 12;
   localparam int CSR_IDX_W        = 1;
   localparam int IMAGE_WIDTH_RST  = 640;
   localparam int IMAGE_HEIGHT_RST = 480;
   localparam int DEF_MAX_WIDTH    = 2048;
   localparam int DEF_MAX_HEIGHT   = 2048;
   localparam int MIN_DIM          = 3;

   // Result buffer depth; it covers the pipeline latency so the stream runs at full rate.
   localparam int FIFO_DEPTH = 16;

   // Gradient arithmetic.
   localparam int SUM_W  = PIXEL_W + 2;
   localparam int GRAD_W = SUM_W + 1;
   localparam int SQ_W   = 2 * GRAD_W - 2;
   localparam int RAD_W  = 2 * PIXEL_W;
   localparam int ROOT_W = PIXEL_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } sobel_csr_type;

   typedef struct packed {
      logic row_last;
      logic frame_last;
   } sobel_mark_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] edge_res;
      sobel_mark_type     mark;
   } sobel_res_type;

endpackage

`default_nettype wire

// ===== rtl/sobel_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with saturation.
// Depends on sobel_pkg.
`default_nettype none

module sobel_isqrt
   import sobel_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   input  logic [RAD_W-1:0]  in_rad,
   input  logic              in_sat,
   input  sobel_mark_type    in_mark,
   output logic              out_vld,
   output logic [ROOT_W-1:0] out_root,
   output sobel_mark_type    out_mark
);

   localparam int TRIAL_W = RAD_W + 1;

   logic              vld_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];
   logic              sat_ff  [ROOT_W];
   sobel_mark_type    mark_ff [ROOT_W];
   logic [RAD_W-1:0]  rem_ff  [ROOT_W-1];
   logic [RAD_W-1:0]  rem_in  [ROOT_W-1];
   logic [RAD_W-1:0]  rem_src [ROOT_W];
   logic [ROOT_W-1:0] root_src[ROOT_W];

   // Each stage tries the next lower root bit: the remainder keeps rad - root*root.
   always_comb begin
      logic [TRIAL_W-1:0] trial;
      logic [TRIAL_W-1:0] rem_ext;
      rem_src[0]  = in_rad;
      root_src[0] = '0;
      for (int i = 1; i < ROOT_W; i++) begin
         rem_src[i]  = rem_ff[i-1];
         root_src[i] = root_ff[i-1];
      end
      for (int i = 0; i < ROOT_W; i++) begin
         trial   = (TRIAL_W'(root_src[i]) << (ROOT_W - i))
                 | (TRIAL_W'(1) << (2 * (ROOT_W - 1 - i)));
         rem_ext = TRIAL_W'(rem_src[i]);
         if (rem_ext >= trial) begin
            root_in[i] = root_src[i] | (ROOT_W'(1) << (ROOT_W - 1 - i));
            if (i < ROOT_W - 1) begin
               rem_in[i] = RAD_W'(rem_ext - trial);
            end
         end else begin
            root_in[i] = root_src[i];
            if (i < ROOT_W - 1) begin
               rem_in[i] = rem_src[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROOT_W; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_vld;
         for (int i = 1; i < ROOT_W; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      sat_ff[0]  <= in_sat;
      mark_ff[0] <= in_mark;
      for (int i = 1; i < ROOT_W; i++) begin
         sat_ff[i]  <= sat_ff[i-1];
         mark_ff[i] <= mark_ff[i-1];
      end
      for (int i = 0; i < ROOT_W; i++) begin
         root_ff[i] <= root_in[i];
      end
      for (int i = 0; i < ROOT_W - 1; i++) begin
         rem_ff[i] <= rem_in[i];
      end
   end

   assign out_vld  = vld_ff[ROOT_W-1];
   assign out_root = sat_ff[ROOT_W-1] ? '1 : root_ff[ROOT_W-1];
   assign out_mark = mark_ff[ROOT_W-1];

endmodule

`default_nettype wire

// ===== rtl/sobel_edge_magnitude_stream.sv =====
// Top level of the Sobel 3x3 edge magnitude stream: line buffer memory, window,
// gradient pipeline and result buffer. Depends on sobel_pkg and sobel_isqrt.
//
//   Channel  Direction  Handshake                 Payload
//   req_     in         req_tvalid / req_tready   tdata: pixel; tuser: frame_start
//   rsp_     out        rsp_tvalid / rsp_tready   tdata: edge_res; tlast: row_last;
//                                                 tuser: frame_last
//   csr_     in         csr_valid / csr_ready     csr_index, csr_data (12 bits)
//
// One pixel word is taken every clock for as long as the result side keeps up. A pixel
// that completes an interior window passes from acceptance through the line buffer read,
// then window, gradient, square, sum and an eight-stage square root into the result
// buffer. The line buffer memory does one read and one write each cycle, which is what
// sets the rate of one pixel a clock.
// req_tready drops only while sixteen results are owed to the output, so a stalled
// output side holds the input after the buffer fills. Reset is synchronous; it clears
// the position, window, pipeline and buffer but not the line buffer memory, so there
// is no clearing pass and the block takes pixels in the cycle after reset.
`default_nettype none

module sobel_edge_magnitude_stream
   import sobel_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
   input  logic                  clock,
   input  logic                  reset,
   // Pixel input
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIXEL_W-1:0]    req_tdata,   // [7:0] pixel
   input  logic                  req_tuser,   // [0] frame_start
   // Edge magnitude output
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIXEL_W-1:0]    rsp_tdata,   // [7:0] edge_res
   output logic                  rsp_tlast,   // row_last
   output logic                  rsp_tuser,   // [0] frame_last
   // Register write port
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Column and row widths: *_IDX holds a position, *C_W also holds the limit itself.
   localparam int W_IDX = $clog2(MAX_WIDTH);
   localparam int WC_W  = $clog2(MAX_WIDTH + 1);
   localparam int H_IDX = $clog2(MAX_HEIGHT);
   localparam int HC_W  = $clog2(MAX_HEIGHT + 1);
   localparam int CWW   = (WC_W > CSR_DATA_W) ? WC_W : CSR_DATA_W;
   localparam int CHW   = (HC_W > CSR_DATA_W) ? HC_W : CSR_DATA_W;
   localparam int WIDTH_RST  = (IMAGE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RST;
   localparam int HEIGHT_RST = (IMAGE_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT
                                                                : IMAGE_HEIGHT_RST;
   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int PEND_W = $clog2(FIFO_DEPTH + 1);
   localparam int LB_W   = 2 * PIXEL_W;

   // ---------------------------------------------------------------------------------
   // Configuration. The registers hold the clamped frame size, which is all the
   // datapath ever uses.
   // ---------------------------------------------------------------------------------
   logic [WC_W-1:0] width_ff,  width_in;
   logic [HC_W-1:0] height_ff, height_in;
   logic [CWW-1:0]  csr_w_ext;
   logic [CHW-1:0]  csr_h_ext;
   logic            csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign csr_w_ext = CWW'(csr_data);
   assign csr_h_ext = CHW'(csr_data);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               if (csr_w_ext < CWW'(MIN_DIM)) begin
                  width_in = WC_W'(MIN_DIM);
               end else if (csr_w_ext > CWW'(MAX_WIDTH)) begin
                  width_in = WC_W'(MAX_WIDTH);
               end else begin
                  width_in = WC_W'(csr_w_ext);
               end
            end
            CSR_IMAGE_HEIGHT: begin
               if (csr_h_ext < CHW'(MIN_DIM)) begin
                  height_in = HC_W'(MIN_DIM);
               end else if (csr_h_ext > CHW'(MAX_HEIGHT)) begin
                  height_in = HC_W'(MAX_HEIGHT);
               end else begin
                  height_in = HC_W'(csr_h_ext);
               end
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Accept stage: position of the incoming pixel, result marks, next position.
   // ---------------------------------------------------------------------------------
   logic              acc;
   logic [W_IDX-1:0]  col_ff, col_in, col_pre, col;
   logic [H_IDX-1:0]  row_ff, row_in, row_pre, row;
   logic [HC_W-1:0]   row_step;
   logic [WC_W-1:0]   col_nx;
   logic [HC_W-1:0]   row_nx;
   logic              prod;
   sobel_mark_type    mark;

   assign acc = req_tvalid && req_tready;

   always_comb begin
      col_pre = req_tuser ? '0 : col_ff;
      row_pre = req_tuser ? '0 : row_ff;

      // A column at or past the width (only after a size change) starts a new row.
      if (WC_W'(col_pre) >= width_ff) begin
         col      = '0;
         row_step = HC_W'(row_pre) + HC_W'(1);
      end else begin
         col      = col_pre;
         row_step = HC_W'(row_pre);
      end
      row = (row_step >= height_ff) ? '0 : H_IDX'(row_step);

      col_nx = WC_W'(col) + WC_W'(1);
      row_nx = HC_W'(row) + HC_W'(1);
      if (col_nx >= width_ff) begin
         col_in = '0;
         row_in = (row_nx >= height_ff) ? '0 : H_IDX'(row_nx);
      end else begin
         col_in = W_IDX'(col_nx);
         row_in = row;
      end

      prod            = (col >= W_IDX'(2)) && (row >= H_IDX'(2));
      mark.row_last   = (col_nx == width_ff);
      mark.frame_last = mark.row_last && (row_nx == height_ff);
   end

   // ---------------------------------------------------------------------------------
   // Line buffer memory. Entry c holds the pixels of column c from the two previous
   // rows: the upper byte is the older row. A pixel reads its column on acceptance and
   // writes back {middle row, new pixel} in the next cycle. When the next pixel reads
   // the entry that is being written in the same cycle, the written word is forwarded.
   // ---------------------------------------------------------------------------------
   logic [LB_W-1:0]    lbuf_mem [MAX_WIDTH];
   logic [LB_W-1:0]    lbuf_rd_ff;
   logic [LB_W-1:0]    fwd_data_ff;
   logic               fwd_ff, fwd_in;
   logic               s1_vld_ff;
   logic               s1_prod_ff;
   sobel_mark_type     s1_mark_ff;
   logic [W_IDX-1:0]   s1_addr_ff;
   logic [PIXEL_W-1:0] s1_pix_ff;
   logic [LB_W-1:0]    lb_word;
   logic [LB_W-1:0]    wr_word;
   logic [PIXEL_W-1:0] top_pix, mid_pix;

   assign fwd_in  = acc && s1_vld_ff && (s1_addr_ff == col);
   assign lb_word = fwd_ff ? fwd_data_ff : lbuf_rd_ff;
   assign top_pix = lb_word[LB_W-1:PIXEL_W];
   assign mid_pix = lb_word[PIXEL_W-1:0];
   assign wr_word = {mid_pix, s1_pix_ff};

   always_ff @(posedge clock) begin
      if (acc) begin
         lbuf_rd_ff <= lbuf_mem[col];
      end
      if (s1_vld_ff) begin
         lbuf_mem[s1_addr_ff] <= wr_word;
      end
   end

   // ---------------------------------------------------------------------------------
   // Window and gradient pipeline.
   // ---------------------------------------------------------------------------------
   logic [PIXEL_W-1:0]       win_ff [3][3];
   logic                     s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff;
   sobel_mark_type           s2_mark_ff, s3_mark_ff, s4_mark_ff, s5_mark_ff;
   logic [SUM_W-1:0]         gx_pos, gx_neg, gy_pos, gy_neg;
   logic [GRAD_W-1:0]        gx_in, gy_in;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;
   logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff;
   logic [SQ_W:0]            sq_sum;
   logic [RAD_W-1:0]         rad_ff;
   logic                     sat_ff;

   // Window rows are oldest row first, columns oldest column first.
   assign gx_pos = SUM_W'(win_ff[0][2]) + {1'b0, win_ff[1][2], 1'b0} + SUM_W'(win_ff[2][2]);
   assign gx_neg = SUM_W'(win_ff[0][0]) + {1'b0, win_ff[1][0], 1'b0} + SUM_W'(win_ff[2][0]);
   assign gy_pos = SUM_W'(win_ff[2][0]) + {1'b0, win_ff[2][1], 1'b0} + SUM_W'(win_ff[2][2]);
   assign gy_neg = SUM_W'(win_ff[0][0]) + {1'b0, win_ff[0][1], 1'b0} + SUM_W'(win_ff[0][2]);
   assign gx_in  = {1'b0, gx_pos} - {1'b0, gx_neg};
   assign gy_in  = {1'b0, gy_pos} - {1'b0, gy_neg};

   assign gx_sq  = gx_ff * gx_ff;
   assign gy_sq  = gy_ff * gy_ff;
   assign sq_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   // ---------------------------------------------------------------------------------
   // Result buffer and credit count. Every accepted pixel that will give a result is
   // counted until its word leaves, so the buffer can never overflow.
   // ---------------------------------------------------------------------------------
   sobel_res_type    fifo_mem [FIFO_DEPTH];
   sobel_res_type    fifo_head;
   logic [PTR_W:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic             rsp_pop;
   logic             root_vld;
   logic [ROOT_W-1:0] root_val;
   sobel_mark_type   root_mark;

   sobel_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (s5_vld_ff),
      .in_rad   (rad_ff),
      .in_sat   (sat_ff),
      .in_mark  (s5_mark_ff),
      .out_vld  (root_vld),
      .out_root (root_val),
      .out_mark (root_mark)
   );

   assign rsp_pop   = rsp_tvalid && rsp_tready;
   assign fifo_head = fifo_mem[rd_ptr_ff[PTR_W-1:0]];
   assign rsp_tvalid = (wr_ptr_ff != rd_ptr_ff);
   assign rsp_tdata  = fifo_head.edge_res;
   assign rsp_tlast  = fifo_head.mark.row_last;
   assign rsp_tuser  = fifo_head.mark.frame_last;
   assign req_tready = (pend_ff != PEND_W'(FIFO_DEPTH));

   always_comb begin
      pend_in = pend_ff;
      priority if ((acc && prod) && !rsp_pop) begin
         pend_in = pend_ff + PEND_W'(1);
      end else if (!(acc && prod) && rsp_pop) begin
         pend_in = pend_ff - PEND_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (root_vld) begin
         fifo_mem[wr_ptr_ff[PTR_W-1:0]] <= '{edge_res: root_val, mark: root_mark};
      end
   end

   // ---------------------------------------------------------------------------------
   // Control registers.
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WC_W'(WIDTH_RST);
         height_ff <= HC_W'(HEIGHT_RST);
         col_ff    <= '0;
         row_ff    <= '0;
         fwd_ff    <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         pend_ff   <= '0;
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[k][j] <= '0;
            end
         end
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         if (acc) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         fwd_ff    <= fwd_in;
         s1_vld_ff <= acc;
         s2_vld_ff <= s1_vld_ff && s1_prod_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         if (root_vld) begin
            wr_ptr_ff <= wr_ptr_ff + (PTR_W + 1)'(1);
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + (PTR_W + 1)'(1);
         end
         pend_ff <= pend_in;
         // Every pixel shifts the window, border pixels included.
         if (s1_vld_ff) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[k][0] <= win_ff[k][1];
               win_ff[k][1] <= win_ff[k][2];
            end
            win_ff[0][2] <= top_pix;
            win_ff[1][2] <= mid_pix;
            win_ff[2][2] <= s1_pix_ff;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Payload registers.
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (acc) begin
         s1_prod_ff <= prod;
         s1_mark_ff <= mark;
         s1_addr_ff <= col;
         s1_pix_ff  <= req_tdata;
      end
      fwd_data_ff <= wr_word;
      s2_mark_ff  <= s1_mark_ff;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      s3_mark_ff  <= s2_mark_ff;
      sqx_ff      <= gx_sq[SQ_W-1:0];
      sqy_ff      <= gy_sq[SQ_W-1:0];
      s4_mark_ff  <= s3_mark_ff;
      rad_ff      <= sq_sum[RAD_W-1:0];
      sat_ff      <= |sq_sum[SQ_W:RAD_W];
      s5_mark_ff  <= s4_mark_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/sobel_chk.sv =====
// Port-level checker for the Sobel edge magnitude stream, with its bind statement.
// Depends on sobel_pkg and sobel_edge_magnitude_stream_defines.svh.
`default_nettype none

`include "sobel_edge_magnitude_stream_defines.svh"

module sobel_chk
   import sobel_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [PIXEL_W-1:0] rsp_tdata,
   input logic               rsp_tlast,
   input logic               rsp_tuser
);

   // A stalled result word stays put.
   `SOBEL_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)), "result word changed while stalled")

   // The end of a frame is always the end of a row as well.
   `SOBEL_ASSERT(a_frame_row, clock, reset, (rsp_tvalid && rsp_tuser) |-> rsp_tlast, "frame end without row end")

   // Reset empties the result buffer and frees every credit.
   `SOBEL_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> (!rsp_tvalid && req_tready), "buffer not empty after reset")

endmodule

bind sobel_edge_magnitude_stream sobel_chk u_sobel_chk (.*);

`default_nettype wire

// ===== sim/tb_sobel_edge_magnitude_stream.sv =====
// Self-checking testbench for the Sobel edge magnitude stream: a pixel driver and an
// edge word monitor around one instance, checked against a line buffer predictor.
// Depends on sobel_pkg and the RTL of sobel_edge_magnitude_stream.
`default_nettype none

module tb_sobel_edge_magnitude_stream;
   import sobel_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The run is stopped here whatever state it is in.
   localparam int CYCLE_LIMIT = 400000;
   // Cycles allowed for in-flight pixels after the last owed edge word has arrived.
   localparam int DRAIN_CYCLES = 24;
   // Length of the long stall on the output side.
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_PIXELS = 800;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               frame_start;
   } pixel_word_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIXEL_W-1:0]    req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [PIXEL_W-1:0]    rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   sobel_csr_type         csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Pixels waiting to be offered, and edge words owed by the block, oldest first.
   pixel_word_t   pixel_backlog[$];
   sobel_res_type owed_edges[$];

   // Register copies and predictor state: two line buffers, the 3x3 window and the
   // position of the next pixel.
   logic [CSR_DATA_W-1:0] width_reg  = CSR_DATA_W'(IMAGE_WIDTH_RST);
   logic [CSR_DATA_W-1:0] height_reg = CSR_DATA_W'(IMAGE_HEIGHT_RST);
   logic [PIXEL_W-1:0]    line_mid [0:DEF_MAX_WIDTH-1];
   logic [PIXEL_W-1:0]    line_top [0:DEF_MAX_WIDTH-1];
   logic [PIXEL_W-1:0]    win [0:2][0:2];
   int unsigned           col_pos = 0;
   int unsigned           row_pos = 0;

   int  tx_idle_pct = 0;
   int  rx_idle_pct = 0;
   bit  hold_trigger = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_left = 0;
   int  cycle_count = 0;
   int  mismatch_count = 0;
   int  pixels_taken = 0;
   int  edges_checked = 0;
   int  frames_closed = 0;
   int  settings_used = 0;
   int  random_pixels = 0;

   sobel_edge_magnitude_stream u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sobel_edge_magnitude_stream verification failed");
         $finish;
      end
   end

   // Register values outside [3, limit] are used as the nearest end of that range.
   function automatic int unsigned clamp_dim(input logic [CSR_DATA_W-1:0] v,
                                             input int unsigned hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
   endfunction

   // Advances the predictor by one accepted pixel and queues the edge word that it
   // completes, if any. Only pixels from the third row and third column on give a word.
   task automatic sobel_step_pixel(input logic [PIXEL_W-1:0] pix, input logic fs);
      int unsigned   w;
      int unsigned   h;
      int unsigned   c;
      int unsigned   r;
      int            gx;
      int            gy;
      int unsigned   sq;
      int unsigned   root;
      int unsigned   trial;
      sobel_res_type word;
      w = clamp_dim(width_reg, DEF_MAX_WIDTH);
      h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      // A register that shrank below the current position wraps it at once.
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;
      for (int k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = line_top[c];
      win[1][2] = line_mid[c];
      win[2][2] = pix;
      line_top[c] = line_mid[c];
      line_mid[c] = pix;
      if (r >= 2 && c >= 2) begin
         gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
            - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
         gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
            - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
         sq = gx * gx + gy * gy;
         // Floored square root bit by bit; anything past 255 squared saturates.
         if (sq >= 65536) begin
            root = 255;
         end else begin
            root = 0;
            for (int b = 7; b >= 0; b--) begin
               trial = root | (1 << b);
               if (trial * trial <= sq) root = trial;
            end
         end
         word.edge_res        = root[PIXEL_W-1:0];
         word.mark.row_last   = (c == w - 1);
         word.mark.frame_last = (c == w - 1) && (r == h - 1);
         owed_edges.push_back(word);
      end
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   // Pixel driver. The word on the bus is predicted at the edge that accepts it, and
   // the next word is put up in the same step, so valid stays high across a run.
   always @(posedge clock) begin : pixel_driver
      pixel_word_t next_word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            sobel_step_pixel(req_tdata, req_tuser);
            pixels_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
               next_word = pixel_backlog.pop_front();
               req_tdata  <= next_word.pixel;
               req_tuser  <= next_word.frame_start;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long output stall, counted here in cycles; the monitor keeps ready low meanwhile.
   always @(posedge clock) begin : hold_counter
      if (reset) begin
         hold_left <= 0;
      end else if (hold_trigger && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Edge word monitor. Each accepted word is checked against the oldest owed one;
   // the ready line idles at random or sits low while the long hold runs.
   always @(posedge clock) begin : edge_monitor
      sobel_res_type owed;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_edges.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("edge word %0h/%0b/%0b arrived with nothing owed",
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               owed = owed_edges.pop_front();
               if (rsp_tdata !== owed.edge_res || rsp_tlast !== owed.mark.row_last ||
                   rsp_tuser !== owed.mark.frame_last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("edge word %0d: expected %0d row_last %0b frame_last %0b, %s %0d %0b %0b",
                              edges_checked, owed.edge_res, owed.mark.row_last,
                              owed.mark.frame_last, "got", rsp_tdata, rsp_tlast, rsp_tuser);
               end
               if (owed.mark.frame_last) frames_closed++;
            end
            edges_checked++;
         end
         if ((hold_trigger && !hold_done) || hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   task automatic set_idling(input int tx_pct, input int rx_pct);
      tx_idle_pct <= tx_pct;
      rx_idle_pct <= rx_pct;
   endtask

   // Writes both registers back to back; valid stays high between the two words.
   task automatic program_frame(input logic [CSR_DATA_W-1:0] w,
                                input logic [CSR_DATA_W-1:0] h);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_data  <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      width_reg = w;
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_data  <= h;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      height_reg = h;
      csr_valid <= 1'b0;
      settings_used++;
      // Queues are touched away from the rising edge so the driver never races them.
      @(negedge clock);
   endtask

   task automatic queue_pixel(input logic [PIXEL_W-1:0] pix, input logic fs);
      pixel_word_t word;
      word.pixel       = pix;
      word.frame_start = fs;
      pixel_backlog.push_back(word);
   endtask

   // Queues count pixels of one texture: uniform noise, black and white only, or a
   // flat patch with slight noise. With noise on, a stray frame start turns up now
   // and then in the middle of a frame.
   task automatic queue_pixels(input int count, input bit start_first, input int style,
                               input bit noisy);
      int                 base;
      logic [PIXEL_W-1:0] pix;
      logic               fs;
      base = $urandom_range(0, 240);
      for (int i = 0; i < count; i++) begin
         case (style)
            0: begin
               pix = $urandom_range(0, 255);
            end
            1: begin
               pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: begin
               pix = base + $urandom_range(0, 15);
            end
         endcase
         fs = (i == 0 && start_first) || (noisy && $urandom_range(0, 59) == 0);
         queue_pixel(pix, fs);
      end
   endtask

   // Waits until every pixel is taken and every owed word has come, then lets the
   // pipeline empty of pixels that owed nothing.
   task automatic wait_drained();
      @(negedge clock);
      while (pixel_backlog.size() != 0 || req_tvalid || owed_edges.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One random stage: a small frame shape, mostly whole frames with random content.
   // The width only grows across a frame start, so no line buffer entry is read
   // before it is written; shrinking may happen in the middle of a frame.
   task automatic random_stage(output int count);
      logic [CSR_DATA_W-1:0] wv;
      logic [CSR_DATA_W-1:0] hv;
      int unsigned           new_w;
      int unsigned           new_h;
      int                    pick;
      bit                    start_first;
      pick = $urandom_range(0, 99);
      if (pick < 8)       wv = $urandom_range(0, 2);
      else if (pick < 14) wv = MIN_DIM;
      else                wv = $urandom_range(4, 16);
      pick = $urandom_range(0, 99);
      if (pick < 8)       hv = $urandom_range(0, 2);
      else if (pick < 14) hv = MIN_DIM;
      else                hv = $urandom_range(4, 10);
      new_w = clamp_dim(wv, DEF_MAX_WIDTH);
      new_h = clamp_dim(hv, DEF_MAX_HEIGHT);
      start_first = (new_w > clamp_dim(width_reg, DEF_MAX_WIDTH)) ||
                    ($urandom_range(0, 3) != 0);
      count = $urandom_range(1, 3) * new_w * new_h;
      if ($urandom_range(0, 3) == 0) count += $urandom_range(0, new_w * new_h - 1);
      program_frame(wv, hv);
      queue_pixels(count, start_first, $urandom_range(0, 2), $urandom_range(0, 9) == 0);
      wait_drained();
   endtask

   initial begin : stimulus
      int count;
      for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
         line_mid[i] = '0;
         line_top[i] = '0;
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            win[i][j] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Register values below the minimum give a 3x3 frame with a
      // single interior pixel.
      set_idling(28, 48);
      program_frame(12'd0, 12'd2);
      // Dark left column against a white right one saturates the magnitude.
      for (int i = 0; i < 3; i++) begin
         queue_pixel(8'd0, i == 0);
         queue_pixel(8'd128, 1'b0);
         queue_pixel(8'd255, 1'b0);
      end
      // Second frame without a frame start: the position wraps by itself.
      queue_pixel(8'd10, 1'b0);  queue_pixel(8'd40, 1'b0); queue_pixel(8'd90, 1'b0);
      queue_pixel(8'd0, 1'b0);   queue_pixel(8'd0, 1'b0);  queue_pixel(8'd0, 1'b0);
      queue_pixel(8'd200, 1'b0); queue_pixel(8'd5, 1'b0);  queue_pixel(8'd60, 1'b0);
      // A flat frame gives no gradient at all.
      for (int i = 0; i < 9; i++) queue_pixel(8'd77, i == 0);
      wait_drained();

      // Width cut in the middle of a row: the column is past the new width and wraps.
      program_frame(12'd8, 12'd5);
      queue_pixels(22, 1'b1, 0, 1'b0);
      wait_drained();
      program_frame(12'd4, 12'd5);
      queue_pixels(20, 1'b0, 0, 1'b0);
      wait_drained();

      // A width past the limit keeps a long first row unbroken; cutting the width
      // afterwards wraps that row and the frame ends at the new size.
      program_frame(12'd4095, 12'd5);
      queue_pixels(300, 1'b1, 0, 1'b0);
      wait_drained();
      program_frame(12'd8, 12'd5);
      queue_pixels(32, 1'b0, 0, 1'b0);
      wait_drained();
      // A height past the limit lets a narrow frame run for many rows.
      program_frame(12'd3, 12'd4095);
      queue_pixels(3 * 60, 1'b1, 1, 1'b0);
      wait_drained();

      // Long stall on the output while the sender keeps offering pixels, so the
      // result buffer fills and the input is held back.
      program_frame(12'd10, 12'd30);
      hold_trigger <= 1'b1;
      queue_pixels(240, 1'b1, 0, 1'b0);
      wait_drained();

      // Random stages: sender idles less than the receiver, then the other way round,
      // then neither idles.
      while (random_pixels < RANDOM_PIXELS) begin
         if (random_pixels < RANDOM_PIXELS / 3)          set_idling(28, 48);
         else if (random_pixels < 2 * RANDOM_PIXELS / 3) set_idling(48, 28);
         else                                           set_idling(0, 0);
         random_stage(count);
         random_pixels += count;
      end

      if (owed_edges.size() != 0) begin
         mismatch_count += owed_edges.size();
         $display("%0d owed edge words never arrived", owed_edges.size());
      end
      $display("Took %0d pixel words under %0d register settings and checked %0d edge words.",
               pixels_taken, settings_used, edges_checked);
      $display("Frame sizes from 3x3 to the clamped maximum, %0d frame ends seen.",
               frames_closed);
      if (mismatch_count == 0) begin
         $display("sobel_edge_magnitude_stream verification clean");
      end else begin
         $display("sobel_edge_magnitude_stream verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sobel_edge_magnitude_stream.f =====
+incdir+rtl
rtl/sobel_pkg.sv
rtl/sobel_isqrt.sv
rtl/sobel_edge_magnitude_stream.sv
rtl/sobel_chk.sv
sim/tb_sobel_edge_magnitude_stream.sv
